@@ sv/dbd_pkg.sv @@
`default_nettype none

package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int STAT_W  = 2;

    // year / 100 by reciprocal: floor(y * RECIP_100 / 2^RECIP_SHIFT) is exact for 14-bit y
    localparam int RECIP_100   = 10486;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = 28;
    localparam int QUOT_W      = 8;
    localparam int REM_W       = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [REM_W-1:0]   REM_LAST  = REM_W'(99);

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BACKWARD = 2'd1,
        STATUS_INVALID  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_EVAL,
        ST_STEP,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic check;
        logic step;
        logic load_out;
    } dbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic invalid;
        logic backward;
        logic at_end;
    } dbd_stat_t;

    // leap rule from year mod 4, year mod 100 and (year / 100) mod 4
    function automatic logic leap_of(input logic [1:0] y_low,
                                     input logic [REM_W-1:0] rem100,
                                     input logic [1:0] quot_low);
        logic leap;
        leap = ((y_low == 2'd0) && (rem100 != '0)) ||
               ((rem100 == '0) && (quot_low == 2'd0));
        return leap;
    endfunction

    // month length, february stretched in a leap year
    function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                       input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ sv/dbd_if.sv @@
`default_nettype none

// date pair channel
interface dbd_date_if
    import dbd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;

    modport source (output valid, start_year, start_month, start_day,
                    end_year, end_month, end_day, input ready);
    modport sink   (input valid, start_year, start_month, start_day,
                    end_year, end_month, end_day, output ready);
endinterface

// result channel
interface dbd_result_if
    import dbd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] day_count;
    logic [STAT_W-1:0]  status;

    modport source (output valid, day_count, status, input ready);
    modport sink   (input valid, day_count, status, output ready);
endinterface

`default_nettype wire

@@ sv/gregorian_days_between_dates.sv @@
// Days between two Gregorian dates.
// dates channel: a start and an end date (year, month, day each) as one item.
// result channel: day_count and status (ok, end before start, invalid date).
// The block takes one item at a time. An accepted item passes the multiply
// and check states (the reciprocal divide by 100 and the date checks) and
// the evaluate state, then the step state advances one day per cycle from
// start to end until it sees the end date, and the finish state loads the
// result register. An invalid or backward pair skips the stepping and goes
// from evaluate to finish, with a zero count. The single-day stepping loop
// sets the run time of a valid pair.
// The result register holds one finished item, so dates.ready rises again
// while that result still waits. A stalled receiver holds the next result
// in the finish state until the register frees up.
// Reset clears the controller and the result valid flag; nothing else needs
// clearing.
`default_nettype none

module gregorian_days_between_dates
    import dbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dbd_date_if.sink     dates,
    dbd_result_if.source result
);

    dbd_cmd_t  cmd;
    dbd_stat_t stat;

    dbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dates.valid),
        .in_ready  (dates.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dbd_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .start_year  (dates.start_year),
        .start_month (dates.start_month),
        .start_day   (dates.start_day),
        .end_year    (dates.end_year),
        .end_month   (dates.end_month),
        .end_day     (dates.end_day),
        .stat        (stat),
        .day_count   (result.day_count),
        .status      (result.status)
    );

endmodule

`default_nettype wire

@@ sv/dbd_ctrl.sv @@
`default_nettype none

module dbd_ctrl
    import dbd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire dbd_stat_t stat,
    output dbd_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MUL;
            ST_MUL:    state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_EVAL;
            ST_EVAL:   state_next = (stat.invalid || stat.backward) ? ST_FINISH : ST_STEP;
            ST_STEP:   if (stat.at_end) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MUL:    cmd.mul = 1'b1;
            ST_CHECK:  cmd.check = 1'b1;
            ST_EVAL:   cmd = '0;
            ST_STEP:   cmd.step = !stat.at_end;
            ST_FINISH: cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/dbd_datapath.sv @@
`default_nettype none

module dbd_datapath
    import dbd_pkg::*;
(
    input  wire logic               clk,
    input  wire dbd_cmd_t           cmd,
    input  wire logic [YEAR_W-1:0]  start_year,
    input  wire logic [MONTH_W-1:0] start_month,
    input  wire logic [DAY_W-1:0]   start_day,
    input  wire logic [YEAR_W-1:0]  end_year,
    input  wire logic [MONTH_W-1:0] end_month,
    input  wire logic [DAY_W-1:0]   end_day,
    output dbd_stat_t               stat,
    output logic [COUNT_W-1:0]      day_count,
    output logic [STAT_W-1:0]       status
);

    logic [YEAR_W-1:0]  cur_y_reg, cur_y_next;
    logic [MONTH_W-1:0] cur_m_reg, cur_m_next;
    logic [DAY_W-1:0]   cur_d_reg, cur_d_next;
    logic [YEAR_W-1:0]  end_y_reg;
    logic [MONTH_W-1:0] end_m_reg;
    logic [DAY_W-1:0]   end_d_reg;
    logic [QUOT_W-1:0]  sq_reg, eq_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [1:0]         quot_reg, quot_next;
    logic [COUNT_W-1:0] count_reg;
    logic               invalid_reg, backward_reg;
    logic [COUNT_W-1:0] res_count_reg;
    status_t            res_status_reg;

    logic [PROD_W-1:0]  sprod, eprod;
    logic [REM_W-1:0]   srem, erem;
    logic               sleap, eleap, cur_leap;
    logic               s_ok, e_ok, back;
    logic [DAY_W-1:0]   cur_len;

    // year / 100 through the reciprocal product
    assign sprod = PROD_W'(cur_y_reg) * PROD_W'(RECIP_100);
    assign eprod = PROD_W'(end_y_reg) * PROD_W'(RECIP_100);

    // remainders from the registered quotients
    assign srem = REM_W'(cur_y_reg - YEAR_W'({sq_reg, 6'd0} + {sq_reg, 5'd0} + {sq_reg, 2'd0}));
    assign erem = REM_W'(end_y_reg - YEAR_W'({eq_reg, 6'd0} + {eq_reg, 5'd0} + {eq_reg, 2'd0}));
    assign sleap = leap_of(cur_y_reg[1:0], srem, sq_reg[1:0]);
    assign eleap = leap_of(end_y_reg[1:0], erem, eq_reg[1:0]);

    // date checks
    assign s_ok = (cur_y_reg >= YEAR_MIN) && (cur_y_reg <= YEAR_MAX) &&
                  (cur_m_reg != '0) && (cur_m_reg <= MONTH_DEC) &&
                  (cur_d_reg != '0) && (cur_d_reg <= days_in_month(sleap, cur_m_reg));
    assign e_ok = (end_y_reg >= YEAR_MIN) && (end_y_reg <= YEAR_MAX) &&
                  (end_m_reg != '0) && (end_m_reg <= MONTH_DEC) &&
                  (end_d_reg != '0) && (end_d_reg <= days_in_month(eleap, end_m_reg));
    assign back = {end_y_reg, end_m_reg, end_d_reg} < {cur_y_reg, cur_m_reg, cur_d_reg};

    // one day forward from the current date
    assign cur_leap = leap_of(cur_y_reg[1:0], rem_reg, quot_reg);
    assign cur_len  = days_in_month(cur_leap, cur_m_reg);

    always_comb
    begin
        cur_y_next = cur_y_reg;
        cur_m_next = cur_m_reg;
        cur_d_next = cur_d_reg + DAY_W'(1);
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        if (cur_d_reg == cur_len)
        begin
            cur_d_next = DAY_W'(1);
            if (cur_m_reg == MONTH_DEC)
            begin
                cur_m_next = MONTH_W'(1);
                cur_y_next = cur_y_reg + YEAR_W'(1);
                if (rem_reg == REM_LAST)
                begin
                    rem_next  = '0;
                    quot_next = quot_reg + 2'd1;
                end
                else
                begin
                    rem_next = rem_reg + REM_W'(1);
                end
            end
            else
            begin
                cur_m_next = cur_m_reg + MONTH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_y_reg <= start_year;
            cur_m_reg <= start_month;
            cur_d_reg <= start_day;
            end_y_reg <= end_year;
            end_m_reg <= end_month;
            end_d_reg <= end_day;
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            cur_y_reg <= cur_y_next;
            cur_m_reg <= cur_m_next;
            cur_d_reg <= cur_d_next;
            rem_reg   <= rem_next;
            quot_reg  <= quot_next;
            count_reg <= count_reg + COUNT_W'(1);
        end
        if (cmd.mul)
        begin
            sq_reg <= sprod[RECIP_SHIFT +: QUOT_W];
            eq_reg <= eprod[RECIP_SHIFT +: QUOT_W];
        end
        if (cmd.check)
        begin
            rem_reg      <= srem;
            quot_reg     <= sq_reg[1:0];
            invalid_reg  <= !(s_ok && e_ok);
            backward_reg <= back;
        end
        if (cmd.load_out)
        begin
            if (invalid_reg)
            begin
                res_status_reg <= STATUS_INVALID;
                res_count_reg  <= '0;
            end
            else if (backward_reg)
            begin
                res_status_reg <= STATUS_BACKWARD;
                res_count_reg  <= '0;
            end
            else
            begin
                res_status_reg <= STATUS_OK;
                res_count_reg  <= count_reg;
            end
        end
    end

    assign stat.invalid  = invalid_reg;
    assign stat.backward = backward_reg;
    assign stat.at_end   = (cur_y_reg == end_y_reg) && (cur_m_reg == end_m_reg) &&
                           (cur_d_reg == end_d_reg);

    assign day_count = res_count_reg;
    assign status    = res_status_reg;

endmodule

`default_nettype wire

@@ sv/dbd_checker.sv @@
`default_nettype none

module dbd_checker
    import dbd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [COUNT_W-1:0] day_count,
    input wire logic [STAT_W-1:0]  status
);

    // a waiting result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(day_count) && $stable(status))
        else $error("result payload changed while stalled");

    // only the three defined codes reach the port
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_BACKWARD) ||
                      (status == STATUS_INVALID))
        else $error("undefined status code");

    // a failed item carries a zero count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> day_count == '0)
        else $error("nonzero count with failing status");

endmodule

bind gregorian_days_between_dates dbd_checker u_dbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .day_count (result.day_count),
    .status    (result.status)
);

`default_nettype wire
